### hw/rtl/pmf_pkg.sv
// Shared types and constants for the polygon mask point flagger.
package pmf_pkg;

	localparam int CW = 32;           // coordinate width, Q16.16
	localparam int PW = 2 * CW + 4;   // exact product / determinant width
	localparam int CfgW = 32;
	localparam int CfgIdxW = 3;
	localparam logic signed [CW:0] QOne = (CW + 1)'(65536);

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_BEGIN  = 2'd1,
		KIND_VERTEX = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_OUTSIDE = 2'd0,
		MODE_INSIDE  = 2'd1,
		MODE_ALL     = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	localparam logic [CfgIdxW-1:0] REG_X_LOW  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_X_HIGH = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_Y_LOW  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_Y_HIGH = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ENABLE = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_MODE   = 3'd5;

	// running extent handed down the cell row
	typedef struct packed {
		logic                 any;
		logic signed [CW-1:0] xmin;
		logic signed [CW-1:0] xmax;
		logic signed [CW-1:0] ymin;
		logic signed [CW-1:0] ymax;
	} ext_t;

	// table update broadcast to the cells
	typedef struct packed {
		logic                 start;
		logic                 add;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} cell_wr_t;

endpackage

### hw/rtl/polygon_mask_point_flagger.sv
// Top level: polygon table load, query sequencer and result register.
//
// Input stream: s_axis_tuser carries the kind (clear, begin polygon, add vertex,
// query), s_axis_tdata the x and y coordinates. Clear, begin and add are handled
// in the idle state as they arrive. A query first lets the extent settle through
// the row of polygon cells, then visits polygons in order: a polygon whose box
// does not strictly hold the point is skipped; for one that does, its edges are
// read one per cycle from the vertex store's single read port and pass a
// four-stage crossing pipeline. The search stops at the first polygon with an
// odd crossing count. Results leave on m_axis through an output register; a new
// item is taken while a result waits, but a query that finishes before the old
// result is taken holds until m_axis_tready. Only one item is in work at a time.
// Reset empties the table, clears the overflow flag, configuration and control
// registers; the vertex store itself is not cleared and needs no clearing pass.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// write it only while idle, since the block itself does not enforce this.
module polygon_mask_point_flagger import pmf_pkg::*; #(
	parameter int MAX_POLYGONS = 16,
	parameter int MAX_VERTS_PER_POLY = 100,
	parameter int VERTEX_STORE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [63:0]          s_axis_tdata,   // coord_x, coord_y
	input  logic [1:0]           s_axis_tuser,   // kind
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [71:0]          m_axis_tdata,   // point_x, point_y, outside_flag,
	                                             // hit_found, polygon_index, overflow_seen
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgW-1:0]      cfg_data
);
	localparam int AW   = $clog2(VERTEX_STORE_DEPTH);
	localparam int VTW  = $clog2(VERTEX_STORE_DEPTH + 1);
	localparam int TW   = $clog2(MAX_POLYGONS + 1);
	localparam int PIW  = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
	localparam int CNTW = $clog2(MAX_VERTS_PER_POLY + 1);
	localparam int ECW  = $clog2(MAX_POLYGONS + 2);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXTENT, ST_POLY, ST_WALK, ST_CLOSE, ST_WRAP,
		ST_DRAIN, ST_DECIDE, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic signed [CW-1:0] lim_xlo_q, lim_xhi_q, lim_ylo_q, lim_yhi_q;
	logic [3:0]           en_q;
	mode_t                mode_q;

	// table bookkeeping
	logic [TW-1:0]   total_q;
	logic [VTW-1:0]  vtotal_q;
	logic [CNTW-1:0] cur_cnt_q;
	logic            open_q;
	logic            ovf_q;

	// query
	logic signed [CW-1:0] qx_q, qy_q;
	logic signed [CW-1:0] gxmin_q, gxmax_q, gymin_q, gymax_q;
	logic signed [CW:0]   rx_q, ry_q;
	logic [ECW-1:0]       ecnt_q;
	logic [TW-1:0]        p_q;
	logic [AW-1:0]        base_q;
	logic [CNTW-1:0]      cnt_q;
	logic [CNTW-1:0]      j_q;
	logic                 par_q;
	logic                 hit_q;
	logic [3:0]           hidx_q;

	// edge walk
	logic                 rv_s1, rfirst_s1;
	logic signed [CW-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;

	// output register
	logic        out_valid_q;
	logic [71:0] out_data_q;

	// input decode
	logic                 in_fire;
	kind_t                kind;
	logic signed [CW-1:0] in_x, in_y;
	logic                 start_ok, add_ok, add_ovf, begin_ovf;
	logic [TW-1:0]        wr_idx;
	cell_wr_t             cell_wr;

	// cell row
	ext_t            ext_w [MAX_POLYGONS + 1];
	logic [AW-1:0]   first_a [MAX_POLYGONS];
	logic [CNTW-1:0] cnt_a [MAX_POLYGONS];
	logic [MAX_POLYGONS-1:0] hit_a;
	ext_t            ext_fin;
	logic signed [CW-1:0] gxmin_c, gxmax_c, gymin_c, gymax_c;
	logic [PIW-1:0]  pi;

	// memory and crossing unit
	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [2*CW-1:0] mem_rdata;
	logic signed [CW-1:0] rd_x, rd_y;
	logic            cx_in_valid, cx_out_valid, cx_out_cross, cx_busy;
	logic signed [CW-1:0] cx_xa, cx_ya, cx_xb, cx_yb;

	logic flag_c, emit_c;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign kind          = kind_t'(s_axis_tuser);
	assign in_x          = s_axis_tdata[CW-1:0];
	assign in_y          = s_axis_tdata[2*CW-1:CW];

	assign start_ok  = in_fire && (kind == KIND_BEGIN) && (total_q < TW'(MAX_POLYGONS));
	assign begin_ovf = in_fire && (kind == KIND_BEGIN) && !(total_q < TW'(MAX_POLYGONS));
	assign add_ok    = in_fire && (kind == KIND_VERTEX) && open_q && (total_q != '0) &&
	                   (cur_cnt_q < CNTW'(MAX_VERTS_PER_POLY)) &&
	                   (vtotal_q < VTW'(VERTEX_STORE_DEPTH));
	assign add_ovf   = in_fire && (kind == KIND_VERTEX) && open_q && (total_q != '0) &&
	                   !add_ok;
	assign wr_idx    = start_ok ? total_q : total_q - 1'b1;

	always_comb begin
		cell_wr.start = start_ok;
		cell_wr.add   = add_ok;
		cell_wr.x     = in_x;
		cell_wr.y     = in_y;
	end

	assign ext_w[0] = '0;

	for (genvar i = 0; i < MAX_POLYGONS; i++) begin : g_cell
		pmf_cell #(.AW(AW), .CNTW(CNTW)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.wr           (cell_wr),
			.sel          (wr_idx == TW'(i)),
			.first_in     (vtotal_q[AW-1:0]),
			.used         (TW'(i) < total_q),
			.qx           (qx_q),
			.qy           (qy_q),
			.ext_in       (ext_w[i]),
			.ext_out      (ext_w[i+1]),
			.first_vertex (first_a[i]),
			.vcount       (cnt_a[i]),
			.box_hit      (hit_a[i])
		);
	end

	assign ext_fin = ext_w[MAX_POLYGONS];
	assign gxmin_c = en_q[0] ? lim_xlo_q : (ext_fin.any ? ext_fin.xmin : '0);
	assign gxmax_c = en_q[1] ? lim_xhi_q : (ext_fin.any ? ext_fin.xmax : '0);
	assign gymin_c = en_q[2] ? lim_ylo_q : (ext_fin.any ? ext_fin.ymin : '0);
	assign gymax_c = en_q[3] ? lim_yhi_q : (ext_fin.any ? ext_fin.ymax : '0);
	assign pi      = p_q[PIW-1:0];

	assign mem_we    = add_ok;
	assign mem_re    = (state_q == ST_WALK);
	assign mem_raddr = base_q + AW'(j_q);
	assign rd_x      = mem_rdata[CW-1:0];
	assign rd_y      = mem_rdata[2*CW-1:CW];

	pmf_vstore #(.DEPTH(VERTEX_STORE_DEPTH), .AW(AW)) u_vstore (
		.clk   (clk),
		.we    (mem_we),
		.waddr (vtotal_q[AW-1:0]),
		.wdata ({in_y, in_x}),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// edges between consecutive reads, then the closing edge back to the first
	assign cx_in_valid = (rv_s1 && !rfirst_s1) || (state_q == ST_WRAP);
	assign cx_xa = prev_x_q;
	assign cx_ya = prev_y_q;
	assign cx_xb = (state_q == ST_WRAP) ? first_x_q : rd_x;
	assign cx_yb = (state_q == ST_WRAP) ? first_y_q : rd_y;

	pmf_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cx_in_valid),
		.rx        (rx_q),
		.ry        (ry_q),
		.qx        (qx_q),
		.qy        (qy_q),
		.xa        (cx_xa),
		.ya        (cx_ya),
		.xb        (cx_xb),
		.yb        (cx_yb),
		.out_valid (cx_out_valid),
		.out_cross (cx_out_cross),
		.busy      (cx_busy)
	);

	assign flag_c = !hit_q && (gxmin_q < qx_q) && (qx_q <= gxmax_q) &&
	                (gymin_q < qy_q) && (qy_q <= gymax_q);

	always_comb begin
		unique case (mode_q)
			MODE_OUTSIDE: emit_c = flag_c;
			MODE_INSIDE:  emit_c = !flag_c;
			MODE_ALL:     emit_c = 1'b1;
			MODE_NONE:    emit_c = 1'b0;
			default:      emit_c = 1'b0;
		endcase
	end

	// walk data path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1     <= 1'b0;
			rfirst_s1 <= 1'b0;
		end else begin
			rv_s1     <= mem_re;
			rfirst_s1 <= (j_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s1) begin
			prev_x_q <= rd_x;
			prev_y_q <= rd_y;
			if (rfirst_s1) begin
				first_x_q <= rd_x;
				first_y_q <= rd_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lim_xlo_q   <= '0;
			lim_xhi_q   <= '0;
			lim_ylo_q   <= '0;
			lim_yhi_q   <= '0;
			en_q        <= '0;
			mode_q      <= MODE_OUTSIDE;
			total_q     <= '0;
			vtotal_q    <= '0;
			cur_cnt_q   <= '0;
			open_q      <= 1'b0;
			ovf_q       <= 1'b0;
			ecnt_q      <= '0;
			p_q         <= '0;
			j_q         <= '0;
			par_q       <= 1'b0;
			hit_q       <= 1'b0;
			hidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_X_LOW:  lim_xlo_q <= cfg_data[CW-1:0];
					REG_X_HIGH: lim_xhi_q <= cfg_data[CW-1:0];
					REG_Y_LOW:  lim_ylo_q <= cfg_data[CW-1:0];
					REG_Y_HIGH: lim_yhi_q <= cfg_data[CW-1:0];
					REG_ENABLE: en_q      <= cfg_data[3:0];
					REG_MODE:   mode_q    <= mode_t'(cfg_data[1:0]);
					default: ;
				endcase
			end

			// in ST_DONE the result register is reloaded below instead
			if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			if (cx_out_valid && cx_out_cross) begin
				par_q <= !par_q;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (kind)
							KIND_CLEAR: begin
								total_q  <= '0;
								vtotal_q <= '0;
								ovf_q    <= 1'b0;
								open_q   <= 1'b0;
							end
							KIND_BEGIN: begin
								if (start_ok) begin
									total_q   <= total_q + 1'b1;
									cur_cnt_q <= '0;
									open_q    <= 1'b1;
								end
								if (begin_ovf) begin
									ovf_q  <= 1'b1;
									open_q <= 1'b0;
								end
							end
							KIND_VERTEX: begin
								if (add_ok) begin
									cur_cnt_q <= cur_cnt_q + 1'b1;
									vtotal_q  <= vtotal_q + 1'b1;
								end
								if (add_ovf) begin
									ovf_q <= 1'b1;
								end
							end
							KIND_QUERY: begin
								qx_q    <= in_x;
								qy_q    <= in_y;
								ecnt_q  <= '0;
								state_q <= ST_EXTENT;
							end
							default: ;
						endcase
					end
				end
				ST_EXTENT: begin
					// let the extent ripple through every cell
					if (ecnt_q == ECW'(MAX_POLYGONS + 1)) begin
						gxmin_q <= gxmin_c;
						gxmax_q <= gxmax_c;
						gymin_q <= gymin_c;
						gymax_q <= gymax_c;
						rx_q    <= (CW + 1)'(gxmin_c) - QOne;
						ry_q    <= (CW + 1)'(gymin_c) - QOne;
						p_q     <= '0;
						hit_q   <= 1'b0;
						hidx_q  <= '0;
						state_q <= ST_POLY;
					end else begin
						ecnt_q <= ecnt_q + 1'b1;
					end
				end
				ST_POLY: begin
					if (p_q >= total_q) begin
						state_q <= ST_DONE;
					end else if (hit_a[pi]) begin
						base_q  <= first_a[pi];
						cnt_q   <= cnt_a[pi];
						j_q     <= '0;
						par_q   <= 1'b0;
						state_q <= ST_WALK;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_WALK: begin
					if (j_q == cnt_q - 1'b1) begin
						state_q <= ST_CLOSE;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_CLOSE: begin
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!cx_busy) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (par_q) begin
						hit_q   <= 1'b1;
						hidx_q  <= 4'(p_q);
						state_q <= ST_DONE;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= ST_POLY;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= emit_c;
						out_data_q  <= {1'b0, ovf_q, hidx_q, hit_q, flag_c, qy_q, qx_q};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_vtotal_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vtotal_q <= VTW'(VERTEX_STORE_DEPTH))
		else $error("vertex total beyond store depth");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(MAX_POLYGONS))
		else $error("polygon total beyond table size");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_cnt_q <= CNTW'(MAX_VERTS_PER_POLY))
		else $error("vertex count beyond polygon limit");

	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> !mem_we)
		else $error("vertex store written during edge walk");

	a_hit_not_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[65] && m_axis_tdata[64]))
		else $error("point both inside a polygon and flagged outside");
endmodule

### hw/rtl/pmf_vstore.sv
// Vertex store: one write and one registered read per cycle.
module pmf_vstore import pmf_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [2*CW-1:0]   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [2*CW-1:0]   rdata
);
	logic [2*CW-1:0] mem [DEPTH];
	logic [2*CW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### hw/rtl/pmf_cell.sv
// One polygon table entry: box, first vertex, count, and a stage of the extent chain.
module pmf_cell import pmf_pkg::*; #(
	parameter int AW = 10,
	parameter int CNTW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_wr_t             wr,
	input  logic                 sel,
	input  logic [AW-1:0]        first_in,
	input  logic                 used,
	input  logic signed [CW-1:0] qx,
	input  logic signed [CW-1:0] qy,
	input  ext_t                 ext_in,
	output ext_t                 ext_out,
	output logic [AW-1:0]        first_vertex,
	output logic [CNTW-1:0]      vcount,
	output logic                 box_hit
);
	logic [AW-1:0]        first_q;
	logic [CNTW-1:0]      cnt_q;
	logic signed [CW-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
	logic                 any_q;
	ext_t                 ext_q;
	ext_t                 ext_next;
	logic                 live;

	always_ff @(posedge clk) begin
		if (sel && wr.start) begin
			first_q <= first_in;
			cnt_q   <= '0;
		end else if (sel && wr.add) begin
			if (cnt_q == '0) begin
				xmin_q <= wr.x;
				xmax_q <= wr.x;
				ymin_q <= wr.y;
				ymax_q <= wr.y;
			end else begin
				if (wr.x < xmin_q) xmin_q <= wr.x;
				if (wr.x > xmax_q) xmax_q <= wr.x;
				if (wr.y < ymin_q) ymin_q <= wr.y;
				if (wr.y > ymax_q) ymax_q <= wr.y;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign live = used && (cnt_q != '0);

	always_comb begin
		ext_next = ext_in;
		if (live) begin
			if (!ext_in.any) begin
				ext_next.any  = 1'b1;
				ext_next.xmin = xmin_q;
				ext_next.xmax = xmax_q;
				ext_next.ymin = ymin_q;
				ext_next.ymax = ymax_q;
			end else begin
				if (xmin_q < ext_in.xmin) ext_next.xmin = xmin_q;
				if (xmax_q > ext_in.xmax) ext_next.xmax = xmax_q;
				if (ymin_q < ext_in.ymin) ext_next.ymin = ymin_q;
				if (ymax_q > ext_in.ymax) ext_next.ymax = ymax_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else begin
			any_q <= ext_next.any;
		end
	end

	always_ff @(posedge clk) begin
		ext_q <= ext_next;
	end

	always_comb begin
		ext_out     = ext_q;
		ext_out.any = any_q;
	end

	assign first_vertex = first_q;
	assign vcount       = cnt_q;
	assign box_hit      = live && (xmin_q < qx) && (qx < xmax_q) &&
	                      (ymin_q < qy) && (qy < ymax_q);
endmodule

### hw/rtl/pmf_cross.sv
// Pipelined strict segment/edge crossing test on exact products (4 stages).
module pmf_cross import pmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW:0]   rx,
	input  logic signed [CW:0]   ry,
	input  logic signed [CW-1:0] qx,
	input  logic signed [CW-1:0] qy,
	input  logic signed [CW-1:0] xa,
	input  logic signed [CW-1:0] ya,
	input  logic signed [CW-1:0] xb,
	input  logic signed [CW-1:0] yb,
	output logic                 out_valid,
	output logic                 out_cross,
	output logic                 busy
);
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [CW:0]   ex_s1, ey_s1, ax_s1, ay_s1;
	logic signed [CW+1:0] dx_s1, dy_s1;
	logic signed [PW-1:0] exdy_s2, eydx_s2, dxay_s2, dyax_s2, axey_s2, ayex_s2;
	logic signed [PW-1:0] d_s3, sn_s3, tn_s3;
	logic                 cross_s4;
	logic                 pos_hit, neg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ex_s1 <= (CW + 1)'(xb) - (CW + 1)'(xa);
		ey_s1 <= (CW + 1)'(yb) - (CW + 1)'(ya);
		ax_s1 <= (CW + 1)'(xa) - (CW + 1)'(qx);
		ay_s1 <= (CW + 1)'(ya) - (CW + 1)'(qy);
		dx_s1 <= (CW + 2)'(qx) - (CW + 2)'(rx);
		dy_s1 <= (CW + 2)'(qy) - (CW + 2)'(ry);

		exdy_s2 <= PW'(ex_s1) * PW'(dy_s1);
		eydx_s2 <= PW'(ey_s1) * PW'(dx_s1);
		dxay_s2 <= PW'(dx_s1) * PW'(ay_s1);
		dyax_s2 <= PW'(dy_s1) * PW'(ax_s1);
		axey_s2 <= PW'(ax_s1) * PW'(ey_s1);
		ayex_s2 <= PW'(ay_s1) * PW'(ex_s1);

		d_s3  <= exdy_s2 - eydx_s2;
		sn_s3 <= dxay_s2 - dyax_s2;
		tn_s3 <= axey_s2 - ayex_s2;

		cross_s4 <= pos_hit || neg_hit;
	end

	// open interval test on both parameters, either sign of the determinant
	assign pos_hit = (d_s3 > 0) && (sn_s3 > 0) && (sn_s3 < d_s3) &&
	                 (tn_s3 > 0) && (tn_s3 < d_s3);
	assign neg_hit = (d_s3 < 0) && (sn_s3 < 0) && (sn_s3 > d_s3) &&
	                 (tn_s3 < 0) && (tn_s3 > d_s3);

	assign out_valid = v_s4;
	assign out_cross = cross_s4;
	assign busy      = v_s1 || v_s2 || v_s3 || v_s4;
endmodule
